>>> hdl/scd_pkg.sv
// Shared types, constants and helpers for the capture-stream deframer.
// Used by scd_front, scd_queue, scd_back and the top level.
package scd_pkg;

    localparam int MAX_FRAME_SIZE_DEF = 1280;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam int TICK_UPPER_W = 20;
    localparam int TICKS_W      = 40;
    localparam int TIME_W       = 45;
    localparam int SIZE_W       = 11;
    localparam int DIGIT_W      = 8;
    localparam int DIV_STAGES   = TICKS_W / DIGIT_W;

    localparam int HDR_STATUS_LEN = 4;
    localparam int HDR_DATA_LEN   = 7;

    localparam int TDATA_W = 96;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_DESYNC  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_TOGGLE = 2'd0,
        ERR_ZERO   = 2'd1,
        ERR_SIZE   = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        TRIG_OFF  = 3'd0,
        TRIG_LOW  = 3'd1,
        TRIG_HIGH = 3'd2,
        TRIG_FALL = 3'd3,
        TRIG_RISE = 3'd4
    } trig_mode_t;

    typedef enum logic [1:0] {
        LT_LOW     = 2'd0,
        LT_HIGH    = 2'd1,
        LT_UNKNOWN = 2'd2
    } last_trig_t;

    // One command from the parser to the executing side
    typedef struct packed {
        kind_t              kind;
        logic               upd_time;
        logic [TICKS_W-1:0] ticks;
        logic [7:0]         b3;
        logic [SIZE_W-1:0]  plen;
        logic [15:0]        duration;
        logic [7:0]         pbyte;
        logic               last;
        err_t               err;
    } cmd_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] q;
        logic [1:0]         r;
    } div_t;

    // One digit of long division by 3, MSB first
    function automatic div_t div3_digit(input logic [1:0] rem_in,
                                        input logic [DIGIT_W-1:0] digit);
        div_t       res;
        logic [2:0] part;
        logic [1:0] r;
        r = rem_in;
        res.q = '0;
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            part = {r, digit[k]};
            if (part >= 3'd3) begin
                res.q[k] = 1'b1;
                r = 2'(part - 3'd3);
            end else begin
                res.q[k] = 1'b0;
                r = part[1:0];
            end
        end
        res.r = r;
        return res;
    endfunction

endpackage

>>> hdl/sniffer_capture_deframer.sv
// Capture-stream deframer for a USB bus sniffer.
// Input: one stream byte per item on s_tdata. Output: one result item per
// completed header, per payload byte, and one for a loss of framing.
// m_tuser carries the result kind, m_tlast marks the final payload byte.
// Config: cfg_data sets the trigger mode; write only while the block is idle.
// Throughput: one byte per cycle while nothing stalls. The parser takes a
// byte every cycle while its command queue has room; the back end retires
// one command per cycle while its output register is free or being taken.
// An accepted byte passes through a queue slot, the five-stage divide-by-3
// pipeline that turns ticks into ns, and the output register to m_tvalid.
// When an output item waits with m_tready low the back end holds; the queue
// keeps s_tready high until it fills (QUEUE_DEPTH items), then s_tready drops.
// After a framing error the block accepts and drops every byte until reset.
// Reset (aresetn low, synchronous) clears framing, the tick extension and
// the frame time, and reloads the capture gate for trigger mode disabled.
// Depends on scd_pkg, scd_front, scd_queue, scd_back.
module sniffer_capture_deframer #(
    parameter int MAX_FRAME_SIZE = scd_pkg::MAX_FRAME_SIZE_DEF,
    parameter int QUEUE_DEPTH    = scd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [44:0] timestamp_ns, [48:45] line_state, [50:49] status_bits,
    // [52:51] bus_speed, [53] capture_on, [64:54] payload_length,
    // [67:65] error_flags, [83:68] duration, [91:84] payload_byte,
    // [93:92] error_code, [95:94] zero
    output logic [scd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,   // [1:0] kind
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_data   // trigger_mode
);
    import scd_pkg::*;

    logic q_push, q_pop, q_empty, q_full;
    cmd_t q_din, q_dout;

    assign cfg_ready = 1'b1;

    scd_front #(
        .MAX_FRAME_SIZE(MAX_FRAME_SIZE)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_byte (s_tdata),
        .q_full  (q_full),
        .push    (q_push),
        .cmd     (q_din)
    );

    scd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .din    (q_din),
        .pop    (q_pop),
        .dout   (q_dout),
        .empty  (q_empty),
        .full   (q_full)
    );

    scd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .cmd_avail(!q_empty),
        .cmd      (q_dout),
        .cmd_pop  (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/scd_front.sv
// Front end: takes stream bytes, tracks framing, checks headers and
// extends the tick count. Emits one command per result. Uses scd_pkg.
module scd_front #(
    parameter int MAX_FRAME_SIZE = scd_pkg::MAX_FRAME_SIZE_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          q_full,
    output logic          push,
    output scd_pkg::cmd_t cmd
);
    import scd_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_SZ = SIZE_W'(MAX_FRAME_SIZE);
    localparam logic [SIZE_W-1:0] MIN_SZ = SIZE_W'(HDR_DATA_LEN);

    logic [7:0]              hs_reg [HDR_DATA_LEN];
    logic [2:0]              idx_reg, idx_next;
    logic                    in_header_reg, in_header_next;
    logic                    is_status_reg, is_status_next;
    logic                    exp_tog_reg, exp_tog_next;
    logic [TICK_UPPER_W-1:0] tick_upper_reg, tick_upper_next;
    logic [SIZE_W-1:0]       rem_reg, rem_next;
    logic                    halted_reg, halted_next;

    logic                    accept;
    logic                    hs_we;
    logic                    st;
    logic [2:0]              last_idx;
    logic [7:0]              h0;
    logic [TICK_UPPER_W-1:0] tu;
    logic [SIZE_W-1:0]       size;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        idx_next        = idx_reg;
        in_header_next  = in_header_reg;
        is_status_next  = is_status_reg;
        exp_tog_next    = exp_tog_reg;
        tick_upper_next = tick_upper_reg;
        rem_next        = rem_reg;
        halted_next     = halted_reg;
        hs_we           = 1'b0;
        push            = 1'b0;
        cmd             = '0;

        st       = (idx_reg == 3'd0) ? !in_byte[7] : is_status_reg;
        last_idx = st ? 3'(HDR_STATUS_LEN - 1) : 3'(HDR_DATA_LEN - 1);
        h0       = hs_reg[0];
        tu       = tick_upper_reg + TICK_UPPER_W'(h0[4]);
        size     = {hs_reg[3][2:0], hs_reg[4]};

        cmd.ticks = {tu, h0[3:0], hs_reg[1], hs_reg[2]};

        if (accept && !halted_reg) begin
            if (!in_header_reg) begin
                rem_next  = rem_reg - 1'b1;
                push      = 1'b1;
                cmd.kind  = KIND_PAYLOAD;
                cmd.pbyte = in_byte;
                cmd.last  = (rem_next == '0);
                if (rem_next == '0) begin
                    in_header_next = 1'b1;
                end
            end else begin
                is_status_next = st;
                hs_we          = 1'b1;
                if (idx_reg != last_idx) begin
                    idx_next = idx_reg + 3'd1;
                end else begin
                    idx_next = '0;
                    push     = 1'b1;
                    if (h0[6] != exp_tog_reg) begin
                        cmd.kind    = KIND_DESYNC;
                        cmd.err     = ERR_TOGGLE;
                        halted_next = 1'b1;
                    end else if (h0[5]) begin
                        cmd.kind    = KIND_DESYNC;
                        cmd.err     = ERR_ZERO;
                        halted_next = 1'b1;
                    end else begin
                        tick_upper_next = tu;
                        exp_tog_next    = !h0[6];
                        cmd.upd_time    = 1'b1;
                        if (st) begin
                            cmd.kind = KIND_STATUS;
                            cmd.b3   = in_byte;
                        end else if (size < MIN_SZ || size > MAX_SZ) begin
                            cmd.kind    = KIND_DESYNC;
                            cmd.err     = ERR_SIZE;
                            halted_next = 1'b1;
                        end else begin
                            rem_next       = size - MIN_SZ;
                            in_header_next = (rem_next == '0);
                            cmd.kind       = KIND_HEADER;
                            cmd.b3         = hs_reg[3];
                            cmd.plen       = rem_next;
                            cmd.duration   = {hs_reg[5], in_byte};
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hs_we) begin
            hs_reg[idx_reg] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            in_header_reg  <= 1'b1;
            is_status_reg  <= 1'b0;
            exp_tog_reg    <= 1'b0;
            tick_upper_reg <= '0;
            rem_reg        <= '0;
            halted_reg     <= 1'b0;
        end else begin
            idx_reg        <= idx_next;
            in_header_reg  <= in_header_next;
            is_status_reg  <= is_status_next;
            exp_tog_reg    <= exp_tog_next;
            tick_upper_reg <= tick_upper_next;
            rem_reg        <= rem_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

>>> hdl/scd_queue.sv
// Short command queue between parser and executing side.
// Register-based ring buffer of scd_pkg::cmd_t entries.
module scd_queue #(
    parameter int DEPTH = scd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  scd_pkg::cmd_t din,
    input  logic          pop,
    output scd_pkg::cmd_t dout,
    output logic          empty,
    output logic          full
);
    import scd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_FULL);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hdl/scd_back.sv
// Back end: tick-to-ns conversion pipeline, capture gate, output register.
// Consumes scd_pkg::cmd_t from scd_queue.
module scd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [2:0]                  cfg_data,
    input  logic                        cmd_avail,
    input  scd_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [scd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);
    import scd_pkg::*;

    typedef struct packed {
        cmd_t               cmd;
        logic [TICKS_W-1:0] quo;
        logic [1:0]         rem;
    } pipe_t;

    pipe_t                 pipe_reg  [DIV_STAGES];
    pipe_t                 pipe_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] pv_reg, pv_next;

    trig_mode_t        mode_reg, mode_next;
    logic              cap_reg, cap_next;
    last_trig_t        lt_reg, lt_next;
    logic [TIME_W-1:0] ft_reg, ft_next;

    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;

    logic              en;
    div_t              dig [DIV_STAGES];
    pipe_t             fin;
    logic [TIME_W-1:0] ft_new;
    logic [TIME_W-1:0] ts;
    logic              trig;
    last_trig_t        trig_lt;
    logic              cap_eval;
    logic              cap_out;
    logic [10:0]       plen;
    logic [2:0]        eflags;
    logic [15:0]       dur;
    logic [7:0]        pbyte;
    logic [1:0]        ecode;
    logic [3:0]        lstate;
    logic [1:0]        sbits;
    logic [1:0]        speed;

    // whole pipeline holds while the output item waits
    assign en      = !out_valid_reg || m_tready;
    assign cmd_pop = en && cmd_avail;

    always_comb begin
        dig[0]            = div3_digit(2'd0, cmd.ticks[TICKS_W-1 -: DIGIT_W]);
        pipe_next[0].cmd  = cmd;
        pipe_next[0].quo  = TICKS_W'(dig[0].q);
        pipe_next[0].rem  = dig[0].r;
        pv_next[0]        = cmd_avail;
        for (int i = 1; i < DIV_STAGES; i++) begin
            dig[i] = div3_digit(pipe_reg[i-1].rem,
                                pipe_reg[i-1].cmd.ticks[TICKS_W-1-DIGIT_W*i -: DIGIT_W]);
            pipe_next[i].cmd = pipe_reg[i-1].cmd;
            pipe_next[i].quo = {pipe_reg[i-1].quo[TICKS_W-DIGIT_W-1:0], dig[i].q};
            pipe_next[i].rem = dig[i].r;
            pv_next[i]       = pv_reg[i-1];
        end
    end

    // ticks*100/6 = 16*t + 2*(t/3) + (1 when t mod 3 is 2)
    always_comb begin
        fin    = pipe_reg[DIV_STAGES-1];
        ft_new = TIME_W'({fin.cmd.ticks, 4'b0000}) + TIME_W'({fin.quo, 1'b0})
                 + TIME_W'(fin.rem == 2'd2);
        trig    = fin.cmd.b3[5];
        trig_lt = trig ? LT_HIGH : LT_LOW;

        cap_eval = cap_reg;
        if (trig_lt != lt_reg) begin
            unique case (mode_reg)
                TRIG_OFF:  cap_eval = 1'b1;
                TRIG_LOW:  cap_eval = !trig;
                TRIG_HIGH: cap_eval = trig;
                TRIG_FALL: cap_eval = cap_reg || (!trig && lt_reg == LT_HIGH);
                TRIG_RISE: cap_eval = cap_reg || (trig && lt_reg == LT_LOW);
                default:   cap_eval = cap_reg;
            endcase
        end

        ts      = fin.cmd.upd_time ? ft_new : ft_reg;
        cap_out = cap_reg;
        plen    = '0;
        eflags  = '0;
        dur     = '0;
        pbyte   = '0;
        ecode   = '0;
        lstate  = '0;
        sbits   = '0;
        speed   = '0;
        out_last_next = 1'b0;
        unique case (fin.cmd.kind)
            KIND_STATUS: begin
                cap_out = cap_eval;
                lstate  = fin.cmd.b3[3:0];
                sbits   = fin.cmd.b3[5:4];
                speed   = fin.cmd.b3[7:6];
            end
            KIND_HEADER: begin
                plen   = fin.cmd.plen;
                eflags = fin.cmd.b3[5:3];
                dur    = fin.cmd.duration;
            end
            KIND_PAYLOAD: begin
                pbyte         = fin.cmd.pbyte;
                out_last_next = fin.cmd.last;
            end
            KIND_DESYNC: begin
                ecode = fin.cmd.err;
            end
        endcase

        // tdata: ts, line state, status, speed, capture, length, flags,
        // duration, payload byte, error code
        out_data_next = {2'b00, ecode, pbyte, dur, eflags, plen, cap_out,
                         speed, sbits, lstate, ts};
        out_kind_next = fin.cmd.kind;
        out_valid_next = en ? pv_reg[DIV_STAGES-1] : out_valid_reg;

        mode_next = mode_reg;
        cap_next  = cap_reg;
        lt_next   = lt_reg;
        ft_next   = ft_reg;
        if (en && pv_reg[DIV_STAGES-1]) begin
            if (fin.cmd.upd_time) begin
                ft_next = ft_new;
            end
            if (fin.cmd.kind == KIND_STATUS) begin
                cap_next = cap_eval;
                lt_next  = trig_lt;
            end
        end
        if (cfg_valid) begin
            mode_next = trig_mode_t'(cfg_data);
            cap_next  = (cfg_data == TRIG_OFF);
            lt_next   = LT_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg        <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= TRIG_OFF;
            cap_reg       <= 1'b1;
            lt_reg        <= LT_UNKNOWN;
            ft_reg        <= '0;
        end else begin
            if (en) begin
                pv_reg <= pv_next;
            end
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            cap_reg       <= cap_next;
            lt_reg        <= lt_next;
            ft_reg        <= ft_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/sniffer_capture_deframer_tb.sv
// Self-checking testbench for sniffer_capture_deframer: capture-stream bytes in,
// status, header, payload and desync result items out, checked field by field.
// Depends on scd_pkg and the sniffer_capture_deframer RTL.
module sniffer_capture_deframer_tb;
    import scd_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;   // outside the defined modes
    localparam int         SETTLE_CYCLES = 12;

    // Result item layout on m_tdata, MSB first
    typedef struct packed {
        logic [1:0]        pad;
        logic [1:0]        error_code;
        logic [7:0]        payload_byte;
        logic [15:0]       duration;
        logic [2:0]        error_flags;
        logic [SIZE_W-1:0] payload_length;
        logic              capture_on;
        logic [1:0]        bus_speed;
        logic [1:0]        status_bits;
        logic [3:0]        line_state;
        logic [TIME_W-1:0] timestamp_ns;
    } frame_fields_t;

    typedef struct packed {
        kind_t         kind;
        logic          last;
        frame_fields_t f;
    } frame_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_data  = 3'd0;

    sniffer_capture_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Deframer state as the testbench sees it
    logic [7:0]          hdr_bytes [HDR_DATA_LEN];
    int                  hdr_count    = 0;
    logic                in_hdr       = 1'b1;
    logic                status_frame = 1'b0;
    logic                want_toggle  = 1'b0;
    logic [TICK_UPPER_W-1:0] tick_hi  = '0;
    logic [TIME_W-1:0]   cur_time     = '0;
    logic [SIZE_W-1:0]   bytes_left   = '0;
    logic                stream_dead  = 1'b0;
    logic                gate_open    = 1'b1;
    last_trig_t          prev_trig    = LT_UNKNOWN;
    logic [2:0]          trig_mode    = TRIG_OFF;

    frame_result_t results_due[$];

    int send_idle_pct = 21;
    int recv_idle_pct = 73;
    int bytes_sent    = 0;
    int mismatches    = 0;
    int modes_written = 0;
    int kind_seen [4] = '{0, 0, 0, 0};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
        $display("sniffer_capture_deframer verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Capture gate update from the status trigger bit
    function automatic void update_gate(input logic t);
        last_trig_t lvl;
        lvl = t ? LT_HIGH : LT_LOW;
        if (lvl == prev_trig) return;
        case (trig_mode)
            TRIG_OFF:  gate_open = 1'b1;
            TRIG_LOW:  gate_open = !t;
            TRIG_HIGH: gate_open = t;
            TRIG_FALL: gate_open = gate_open || (!t && prev_trig == LT_HIGH);
            TRIG_RISE: gate_open = gate_open || (t && prev_trig == LT_LOW);
            default:   ;
        endcase
        prev_trig = lvl;
    endfunction

    function automatic void flag_desync(input err_t code);
        frame_result_t r;
        r = '0;
        r.kind = KIND_DESYNC;
        r.f.timestamp_ns = cur_time;
        r.f.capture_on = gate_open;
        r.f.error_code = code;
        stream_dead = 1'b1;
        results_due.push_back(r);
    endfunction

    // Advance the deframer state by one stream byte, queue any result it yields
    function automatic void deframe_byte(input logic [7:0] b);
        frame_result_t r;
        int            need;
        logic [7:0]    h0;
        logic [7:0]    b3;
        logic [63:0]   ticks;
        logic [SIZE_W-1:0] size;
        r = '0;
        if (stream_dead) return;
        if (!in_hdr) begin
            bytes_left = bytes_left - 1'b1;
            r.kind = KIND_PAYLOAD;
            r.f.timestamp_ns = cur_time;
            r.f.capture_on = gate_open;
            r.f.payload_byte = b;
            if (bytes_left == 0) begin
                r.last = 1'b1;
                in_hdr = 1'b1;
                hdr_count = 0;
            end
            results_due.push_back(r);
            return;
        end
        if (hdr_count == 0) status_frame = !b[7];
        need = status_frame ? HDR_STATUS_LEN : HDR_DATA_LEN;
        hdr_bytes[hdr_count] = b;
        hdr_count++;
        if (hdr_count < need) return;
        hdr_count = 0;

        h0 = hdr_bytes[0];
        // toggle fault wins when the zero bit is also set
        if (h0[6] != want_toggle) begin
            flag_desync(ERR_TOGGLE);
            return;
        end
        if (h0[5]) begin
            flag_desync(ERR_ZERO);
            return;
        end
        if (h0[4]) tick_hi = tick_hi + 1'b1;
        ticks = {24'd0, tick_hi, h0[3:0], hdr_bytes[1], hdr_bytes[2]};
        cur_time = TIME_W'((ticks * 64'd100) / 64'd6);
        want_toggle = !h0[6];
        b3 = hdr_bytes[3];

        if (status_frame) begin
            update_gate(b3[5]);
            r.kind = KIND_STATUS;
            r.f.timestamp_ns = cur_time;
            r.f.line_state = b3[3:0];
            r.f.status_bits = b3[5:4];
            r.f.bus_speed = b3[7:6];
            r.f.capture_on = gate_open;
            results_due.push_back(r);
            return;
        end

        size = {b3[2:0], hdr_bytes[4]};
        // size desync reports the freshly computed frame time
        if (size < HDR_DATA_LEN || size > MAX_FRAME_SIZE_DEF) begin
            flag_desync(ERR_SIZE);
            return;
        end
        bytes_left = size - SIZE_W'(HDR_DATA_LEN);
        in_hdr = (bytes_left == 0);
        r.kind = KIND_HEADER;
        r.f.timestamp_ns = cur_time;
        r.f.capture_on = gate_open;
        r.f.payload_length = bytes_left;
        r.f.error_flags = b3[5:3];
        r.f.duration = {hdr_bytes[5], hdr_bytes[6]};
        results_due.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        frame_result_t want;
        frame_fields_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result item, kind %0d, data %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                kind_seen[want.kind]++;
                check_field("kind", want.kind, m_tuser);
                check_field("last", want.last, m_tlast);
                check_field("timestamp_ns", want.f.timestamp_ns, got.timestamp_ns);
                check_field("line_state", want.f.line_state, got.line_state);
                check_field("status_bits", want.f.status_bits, got.status_bits);
                check_field("bus_speed", want.f.bus_speed, got.bus_speed);
                check_field("capture_on", want.f.capture_on, got.capture_on);
                check_field("payload_length", want.f.payload_length, got.payload_length);
                check_field("error_flags", want.f.error_flags, got.error_flags);
                check_field("duration", want.f.duration, got.duration);
                check_field("payload_byte", want.f.payload_byte, got.payload_byte);
                check_field("error_code", want.f.error_code, got.error_code);
                check_field("pad", want.f.pad, got.pad);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    // Let in-flight work finish before touching the trigger mode
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_trigger_mode(input logic [2:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        trig_mode = m;
        gate_open = (m == TRIG_OFF);
        prev_trig = LT_UNKNOWN;
        modes_written++;
    endtask

    task automatic send_status_frame(input logic ovf, input logic [19:0] tick,
                                     input logic [7:0] st);
        send_byte({1'b0, want_toggle, 1'b0, ovf, tick[19:16]});
        send_byte(tick[15:8]);
        send_byte(tick[7:0]);
        send_byte(st);
    endtask

    task automatic send_data_frame(input logic ovf, input logic [19:0] tick,
                                   input logic [4:0] flags_hi, input logic [10:0] size,
                                   input logic [15:0] dur);
        send_byte({1'b1, want_toggle, 1'b0, ovf, tick[19:16]});
        send_byte(tick[15:8]);
        send_byte(tick[7:0]);
        send_byte({flags_hi, size[10:8]});
        send_byte(size[7:0]);
        send_byte(dur[15:8]);
        send_byte(dur[7:0]);
        for (int i = HDR_DATA_LEN; i < size; i++) send_byte(8'($urandom));
    endtask

    // Field extremes, overflow carry, and a data frame with no payload
    task automatic test_header_extremes();
        send_status_frame(1'b1, 20'hFFFFF, 8'hFF);
        send_status_frame(1'b0, 20'h00000, 8'h00);
        send_data_frame(1'b1, 20'hFFFFF, 5'h1F, 11'd7, 16'hFFFF);
        send_data_frame(1'b0, 20'h00000, 5'h00, 11'd8, 16'h0000);
    endtask

    // Well-formed random frames under one trigger mode and one idling mix
    task automatic test_trigger_traffic(input logic [2:0] m, input int snd_pct,
                                        input int rcv_pct, input int n_bytes,
                                        input bit with_max_frame);
        int start;
        int nframes;
        logic [10:0] size;
        settle();
        write_trigger_mode(m);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = bytes_sent;
        nframes = 0;
        if (with_max_frame)
            send_data_frame(1'($urandom), 20'($urandom), 5'($urandom),
                            11'(MAX_FRAME_SIZE_DEF), 16'($urandom));
        while (bytes_sent - start < n_bytes) begin
            if (nframes == 10) drain_results();
            if ($urandom_range(1)) begin
                send_status_frame($urandom_range(3) == 0, 20'($urandom), 8'($urandom));
            end else begin
                size = ($urandom_range(9) == 0) ? 11'($urandom_range(25, 200))
                                                : 11'($urandom_range(7, 24));
                send_data_frame($urandom_range(3) == 0, 20'($urandom), 5'($urandom),
                                size, 16'($urandom));
            end
            nframes++;
        end
    endtask

    // One loss of framing, then bytes that must all be dropped
    task automatic test_framing_loss();
        logic       is_data;
        logic [7:0] h0;
        logic [10:0] size;
        int         fault;
        settle();
        is_data = 1'($urandom);
        fault = $urandom_range(2);
        size = 11'($urandom_range(7, 40));
        h0 = {is_data, want_toggle, 1'b0, 1'($urandom), 4'($urandom)};
        case (fault)
            0: h0[6:5] = {!want_toggle, 1'($urandom)};  // zero bit may be set as well
            1: h0[5] = 1'b1;
            default: begin
                h0[7] = 1'b1;
                is_data = 1'b1;
                size = $urandom_range(1) ? 11'($urandom_range(0, 6))
                                         : 11'($urandom_range(MAX_FRAME_SIZE_DEF + 1, 2047));
            end
        endcase
        send_byte(h0);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        if (is_data) begin
            send_byte({5'($urandom), size[10:8]});
            send_byte(size[7:0]);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end else begin
            send_byte(8'($urandom));
        end
        repeat (16) send_byte(8'($urandom));
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_header_extremes();
        test_trigger_traffic(TRIG_LOW,    21, 73, 180, 1'b0);
        test_trigger_traffic(TRIG_HIGH,   21, 73, 180, 1'b0);
        test_trigger_traffic(TRIG_FALL,   73, 21, 180, 1'b0);
        test_trigger_traffic(TRIG_RISE,   73, 21, 180, 1'b0);
        test_trigger_traffic(MODE_UNUSED,  0,  0, 180, 1'b0);
        test_trigger_traffic(TRIG_OFF,     0,  0, 180, 1'b0);
        test_framing_loss();
        settle();

        $display("Sent %0d stream bytes over %0d trigger settings; checked %0d status,",
                 bytes_sent, modes_written, kind_seen[KIND_STATUS]);
        $display("%0d header, %0d payload and %0d desync items; %0d mismatches.",
                 kind_seen[KIND_HEADER], kind_seen[KIND_PAYLOAD], kind_seen[KIND_DESYNC],
                 mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("sniffer_capture_deframer verification clean");
        end else begin
            $display("sniffer_capture_deframer verification failed");
        end
        $finish;
    end

endmodule
